// ===== rtl/pvpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pvpc_pkg
// Shared types, constants and the segment table of the volume pot controller.
// ----------------------------------------------------------------------------
package pvpc_pkg;

    localparam int FULL_SCALE_PULSES = 100;
    localparam int MAX_VOLUME        = 7;
    localparam int VOL_W             = 4;
    localparam int PULSE_W           = 7;
    localparam int DUR_W             = 16;
    localparam int CMD_W             = 3;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUTE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MIC    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRESET = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_UNIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS   = 2'd3;

    localparam logic [DUR_W-1:0]   RST_LONG_PRESS  = 16'd2000;
    localparam logic [DUR_W-1:0]   RST_STEP_UNIT   = 16'd1000;
    localparam logic [PULSE_W-1:0] RST_PULSES_STEP = 7'd10;
    localparam logic [PULSE_W-1:0] RST_START_POS   = 7'd30;
    localparam logic [VOL_W-1:0]   RST_VOLUME      = 4'd3;

    typedef struct packed {
        logic [DUR_W-1:0]   long_press_ms;
        logic [DUR_W-1:0]   step_unit_ms;
        logic [PULSE_W-1:0] pulses_per_step;
        logic [PULSE_W-1:0] start_position;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             long_press;
        logic [DUR_W-1:0] duration_ms;
    } item_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DUR_W-1:0] quotient;
    } div_status_t;

    function automatic logic [7:0] seg_pattern(input logic [VOL_W-1:0] v);
        logic [7:0] s;
        case (v)
            4'd0:    s = 8'h77;
            4'd1:    s = 8'h14;
            4'd2:    s = 8'hB3;
            4'd3:    s = 8'hB6;
            4'd4:    s = 8'hD4;
            4'd5:    s = 8'hE6;
            4'd6:    s = 8'hE7;
            4'd7:    s = 8'h34;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/press_volume_pot_controller_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// press_volume_pot_controller_core
// Volume controller for an up/down digital pot: config registers, front queue,
// back-end sequencer and long press divider.
// ----------------------------------------------------------------------------
// An accepted word is queued; the back end then registers its result word.
// Throughput: one word per cycle while the output is free, except a long
//   up/down press taken while idle, which holds the back end until the divider
//   is done. A 2-word front queue keeps input accepted in a stall until full.
// Reset: asynchronous, active low; idle, volume 3, pins and switches low,
//   registers at 2000 / 1000 / 10 / 30.
module press_volume_pot_controller_core
    import pvpc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DUR_W-1:0]      s_tdata,   // duration_ms
    input  wire logic [CMD_W-1:0]      s_tuser,   // command
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pot_cs, pot_ud, pot_inc, volume[2:0], segments[7:0], mute_on, mic_on,
    // light_on, busy_res, dropped, zero fill
    output logic [23:0]                m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg_reg;
    logic             q_valid;
    item_t            q_item;
    logic             q_pop;
    logic             div_start;
    logic [DUR_W-1:0] div_dividend;
    logic [DUR_W-1:0] div_divisor;
    div_status_t      div_st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms   <= RST_LONG_PRESS;
            cfg_reg.step_unit_ms    <= RST_STEP_UNIT;
            cfg_reg.pulses_per_step <= RST_PULSES_STEP;
            cfg_reg.start_position  <= RST_START_POS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LONG_PRESS:  cfg_reg.long_press_ms   <= cfg_data;
                REG_STEP_UNIT:   cfg_reg.step_unit_ms    <= cfg_data;
                REG_PULSES_STEP: cfg_reg.pulses_per_step <= cfg_data[PULSE_W-1:0];
                REG_START_POS:   cfg_reg.start_position  <= cfg_data[PULSE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    pvpc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .long_press_ms (cfg_reg.long_press_ms),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    pvpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_st)
    );

    pvpc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_st       (div_st),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    a_drop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[18]) |-> m_tdata[17])
        else $error("dropped word reported with sequence idle");

    a_segments_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:6] == seg_pattern({1'b0, m_tdata[5:3]})))
        else $error("segment pattern does not match volume");

    a_div_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while running");

    a_div_start_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_st.busy)
        else $error("divider did not start");

endmodule
`default_nettype wire

// ===== rtl/pvpc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pvpc_front
// Accept input words, classify press length and queue them for the back end.
// ----------------------------------------------------------------------------
module pvpc_front
    import pvpc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [DUR_W-1:0] s_tdata,   // duration_ms
    input  wire logic [CMD_W-1:0] s_tuser,   // command
    input  wire logic [DUR_W-1:0] long_press_ms,
    output logic                  q_valid,
    output item_t                 q_item,
    input  wire logic             q_pop
);

    localparam int DEPTH = 2;

    item_t      mem_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    item_t      new_item;

    assign s_tready = (count_reg != 2'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.command     = s_tuser;
        new_item.duration_ms = s_tdata;
        new_item.long_press  = (s_tdata >= long_press_ms);
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pvpc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pvpc_div
// Bit-serial restoring divider for long press step counts, one bit a cycle.
// ----------------------------------------------------------------------------
module pvpc_div
    import pvpc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DUR_W-1:0] dividend,
    input  wire logic [DUR_W-1:0] divisor,
    output div_status_t           status
);

    localparam int CNT_W = $clog2(DUR_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DUR_W-1:0] rem_reg, rem_next;
    logic [DUR_W-1:0] quo_reg, quo_next;
    logic [DUR_W-1:0] dvs_reg, dvs_next;
    logic [DUR_W:0]   trial;

    assign trial = {rem_reg, quo_reg[DUR_W-1]} - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next  = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(DUR_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (run_reg)
        begin
            if (!trial[DUR_W])
            begin
                rem_next = trial[DUR_W-1:0];
            end
            else
            begin
                rem_next = {rem_reg[DUR_W-2:0], quo_reg[DUR_W-1]};
            end
            quo_next = {quo_reg[DUR_W-2:0], ~trial[DUR_W]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy     = run_reg;
    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/pvpc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pvpc_back
// Execute queued words: pin sequencer, volume, switches and result register.
// ----------------------------------------------------------------------------
module pvpc_back
    import pvpc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             q_valid,
    input  wire item_t            q_item,
    output logic                  q_pop,
    output logic                  div_start,
    output logic [DUR_W-1:0]      div_dividend,
    output logic [DUR_W-1:0]      div_divisor,
    input  wire div_status_t      div_st,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [23:0]           m_tdata
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_PRE_INC  = 4'd1;
    localparam logic [3:0] PH_CS_LOW   = 4'd2;
    localparam logic [3:0] PH_UD_SET   = 4'd3;
    localparam logic [3:0] PH_PULSE_HI = 4'd4;
    localparam logic [3:0] PH_PULSE_LO = 4'd5;
    localparam logic [3:0] PH_UD_UP    = 4'd6;
    localparam logic [3:0] PH_POST_INC = 4'd7;
    localparam logic [3:0] PH_CS_HIGH  = 4'd8;
    localparam logic [3:0] PH_UD_FINAL = 4'd9;
    localparam logic [3:0] PH_SWEEP_HI = 4'd10;
    localparam logic [3:0] PH_SWEEP_LO = 4'd11;

    localparam logic CTL_RUN = 1'b0;
    localparam logic CTL_DIV = 1'b1;

    localparam logic [VOL_W-1:0]   VOL_MAX    = VOL_W'(MAX_VOLUME);
    localparam logic [PULSE_W-1:0] FULL_SCALE = PULSE_W'(FULL_SCALE_PULSES);

    logic               ctl_reg, ctl_next;
    logic               div_up_reg, div_up_next;
    logic [3:0]         phase_reg, phase_next;
    logic [1:0]         ticks_reg, ticks_next;
    logic [PULSE_W-1:0] pulses_reg, pulses_next;
    logic [VOL_W-1:0]   steps_reg, steps_next;
    logic               up_reg, up_next;
    logic               preset_reg, preset_next;
    logic [VOL_W-1:0]   vol_reg, vol_next;
    logic               cs_reg, cs_next;
    logic               ud_reg, ud_next;
    logic               inc_reg, inc_next;
    logic               mute_reg, mute_next;
    logic               mic_reg, mic_next;
    logic               light_reg, light_next;
    logic               out_valid_reg, out_valid_next;
    logic [23:0]        out_data_reg;

    logic               busy;
    logic               out_free;
    logic               fire;
    logic               finish;
    logic               is_press;
    logic               press_up;
    logic               press_go;
    logic [VOL_W-1:0]   room;
    logic [VOL_W-1:0]   press_n;
    logic               drop;
    logic               out_load;
    logic               do_enter;
    logic [3:0]         enter_ph;
    logic [23:0]        out_word;

    assign busy      = (phase_reg != PH_IDLE);
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = (ctl_reg == CTL_RUN) && q_valid && out_free;
    assign finish    = (ctl_reg == CTL_DIV) && div_st.done && out_free;
    assign q_pop     = fire;
    assign is_press  = (q_item.command == CMD_UP) || (q_item.command == CMD_DOWN);
    assign div_start = fire && is_press && !busy && q_item.long_press;
    assign div_dividend = q_item.duration_ms;
    assign div_divisor  = (cfg.step_unit_ms == '0) ? DUR_W'(1) : cfg.step_unit_ms;

    assign press_up = (ctl_reg == CTL_DIV) ? div_up_reg : (q_item.command == CMD_UP);
    assign room     = press_up ? (VOL_MAX - vol_reg) : vol_reg;

    always_comb
    begin
        if (ctl_reg == CTL_DIV)
        begin
            press_n = (div_st.quotient > DUR_W'(room)) ? room
                                                        : div_st.quotient[VOL_W-1:0];
        end
        else
        begin
            press_n = (room != '0) ? VOL_W'(1) : '0;
        end
    end

    always_comb
    begin
        ctl_next    = ctl_reg;
        div_up_next = div_up_reg;
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        pulses_next = pulses_reg;
        steps_next  = steps_reg;
        up_next     = up_reg;
        preset_next = preset_reg;
        vol_next    = vol_reg;
        cs_next     = cs_reg;
        ud_next     = ud_reg;
        inc_next    = inc_reg;
        mute_next   = mute_reg;
        mic_next    = mic_reg;
        light_next  = light_reg;
        drop        = 1'b0;
        press_go    = 1'b0;
        do_enter    = 1'b0;
        enter_ph    = PH_IDLE;

        if (finish)
        begin
            ctl_next = CTL_RUN;
            press_go = 1'b1;
        end
        else if (fire)
        begin
            case (q_item.command)
                CMD_TICK:
                begin
                    if (busy)
                    begin
                        if (ticks_reg > 2'd1)
                        begin
                            ticks_next = ticks_reg - 2'd1;
                        end
                        else
                        begin
                            do_enter = 1'b1;
                            case (phase_reg)
                                PH_PRE_INC: enter_ph = PH_CS_LOW;
                                PH_CS_LOW:  enter_ph = PH_UD_SET;
                                PH_UD_SET:
                                begin
                                    if (preset_reg)
                                    begin
                                        pulses_next = FULL_SCALE;
                                        enter_ph    = PH_SWEEP_HI;
                                    end
                                    else
                                    begin
                                        pulses_next = cfg.pulses_per_step;
                                        enter_ph    = (cfg.pulses_per_step != '0) ?
                                                      PH_PULSE_HI : PH_POST_INC;
                                    end
                                end
                                PH_SWEEP_HI: enter_ph = PH_SWEEP_LO;
                                PH_SWEEP_LO:
                                begin
                                    if (pulses_reg != '0)
                                    begin
                                        pulses_next = pulses_reg - PULSE_W'(1);
                                    end
                                    enter_ph = (pulses_next != '0) ? PH_SWEEP_HI : PH_UD_UP;
                                end
                                PH_UD_UP:
                                begin
                                    pulses_next = cfg.start_position;
                                    enter_ph    = (cfg.start_position != '0) ?
                                                  PH_PULSE_HI : PH_POST_INC;
                                end
                                PH_PULSE_HI: enter_ph = PH_PULSE_LO;
                                PH_PULSE_LO:
                                begin
                                    if (pulses_reg != '0)
                                    begin
                                        pulses_next = pulses_reg - PULSE_W'(1);
                                    end
                                    enter_ph = (pulses_next != '0) ? PH_PULSE_HI
                                                                    : PH_POST_INC;
                                end
                                PH_POST_INC: enter_ph = PH_CS_HIGH;
                                PH_CS_HIGH:  enter_ph = PH_UD_FINAL;
                                PH_UD_FINAL:
                                begin
                                    inc_next = 1'b1;
                                    if (!preset_reg)
                                    begin
                                        if (up_reg)
                                        begin
                                            if (vol_reg < VOL_MAX)
                                            begin
                                                vol_next = vol_reg + VOL_W'(1);
                                            end
                                        end
                                        else if (vol_reg != '0)
                                        begin
                                            vol_next = vol_reg - VOL_W'(1);
                                        end
                                        if (steps_reg != '0)
                                        begin
                                            steps_next = steps_reg - VOL_W'(1);
                                        end
                                    end
                                    else
                                    begin
                                        steps_next = '0;
                                    end
                                    if (steps_next != '0)
                                    begin
                                        enter_ph = PH_PRE_INC;
                                    end
                                    else
                                    begin
                                        preset_next = 1'b0;
                                        enter_ph    = PH_IDLE;
                                    end
                                end
                                default: enter_ph = PH_IDLE;
                            endcase
                        end
                    end
                end
                CMD_UP, CMD_DOWN:
                begin
                    if (busy)
                    begin
                        drop = 1'b1;
                    end
                    else if (q_item.long_press)
                    begin
                        ctl_next    = CTL_DIV;
                        div_up_next = (q_item.command == CMD_UP);
                    end
                    else
                    begin
                        press_go = 1'b1;
                    end
                end
                CMD_MUTE:
                begin
                    if (busy)
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        mute_next = ~mute_reg;
                        if (mute_reg)
                        begin
                            light_next = ~light_reg;
                        end
                    end
                end
                CMD_MIC:
                begin
                    if (busy)
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        mic_next = ~mic_reg;
                    end
                end
                CMD_PRESET:
                begin
                    if (busy)
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        preset_next = 1'b1;
                        up_next     = 1'b0;
                        steps_next  = '0;
                        do_enter    = 1'b1;
                        enter_ph    = PH_PRE_INC;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (press_go && (press_n != '0))
        begin
            steps_next  = press_n;
            up_next     = press_up;
            preset_next = 1'b0;
            do_enter    = 1'b1;
            enter_ph    = PH_PRE_INC;
        end

        if (do_enter)
        begin
            phase_next = enter_ph;
            case (enter_ph)
                PH_PRE_INC, PH_POST_INC:
                begin
                    inc_next   = 1'b1;
                    ticks_next = 2'd2;
                end
                PH_CS_LOW:
                begin
                    cs_next    = 1'b0;
                    ticks_next = 2'd2;
                end
                PH_CS_HIGH:
                begin
                    cs_next    = 1'b1;
                    ticks_next = 2'd2;
                end
                PH_UD_SET:
                begin
                    ud_next    = up_next;
                    ticks_next = 2'd2;
                end
                PH_PULSE_HI, PH_SWEEP_HI:
                begin
                    inc_next   = 1'b1;
                    ticks_next = 2'd1;
                end
                PH_PULSE_LO, PH_SWEEP_LO:
                begin
                    inc_next   = 1'b0;
                    ticks_next = 2'd1;
                end
                PH_UD_UP:
                begin
                    ud_next    = 1'b1;
                    up_next    = 1'b1;
                    ticks_next = 2'd1;
                end
                PH_UD_FINAL:
                begin
                    ud_next    = up_next && !preset_next;
                    ticks_next = 2'd2;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    ticks_next = 2'd0;
                end
            endcase
        end
    end

    assign out_load = (fire && !div_start) || finish;

    always_comb
    begin
        out_word        = '0;
        out_word[0]     = cs_next;
        out_word[1]     = ud_next;
        out_word[2]     = inc_next;
        out_word[5:3]   = vol_next[2:0];
        out_word[13:6]  = seg_pattern(vol_next);
        out_word[14]    = mute_next;
        out_word[15]    = mic_next;
        out_word[16]    = light_next;
        out_word[17]    = (phase_next != PH_IDLE);
        out_word[18]    = drop;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= CTL_RUN;
            div_up_reg    <= 1'b0;
            phase_reg     <= PH_IDLE;
            ticks_reg     <= 2'd0;
            pulses_reg    <= '0;
            steps_reg     <= '0;
            up_reg        <= 1'b0;
            preset_reg    <= 1'b0;
            vol_reg       <= RST_VOLUME;
            cs_reg        <= 1'b0;
            ud_reg        <= 1'b0;
            inc_reg       <= 1'b0;
            mute_reg      <= 1'b0;
            mic_reg       <= 1'b0;
            light_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            div_up_reg    <= div_up_next;
            phase_reg     <= phase_next;
            ticks_reg     <= ticks_next;
            pulses_reg    <= pulses_next;
            steps_reg     <= steps_next;
            up_reg        <= up_next;
            preset_reg    <= preset_next;
            vol_reg       <= vol_next;
            cs_reg        <= cs_next;
            ud_reg        <= ud_next;
            inc_reg       <= inc_next;
            mute_reg      <= mute_next;
            mic_reg       <= mic_next;
            light_reg     <= light_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire
